// ----- sv/tpls_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the thermal head line sequencer.
// Used by tpls_line_buf and thermal_head_line_sequencer_core.
package tpls_pkg;

    localparam int LINE_MAX = 64;
    localparam int GROUPS   = 6;
    localparam int STB_W    = 6;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int CNT_W    = $clog2(LINE_MAX) + 1;
    localparam int GI_W     = 3;
    localparam int GS_W     = 4;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] REG_LINE_BYTES  = 3'd0;
    localparam logic [2:0] REG_LATCH_TICKS = 3'd1;
    localparam logic [2:0] REG_HEAT_TICKS  = 3'd2;
    localparam logic [2:0] REG_STROBE_MASK = 3'd3;
    localparam logic [2:0] REG_SEQ_HEAT    = 3'd4;
    localparam logic [2:0] REG_AUTO_CLEAR  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_LATCH,
        PH_HEAT
    } t_phase;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
        logic              clear;
    } t_buf_ctrl;

    // first selected group at or after start, GROUPS when none
    function automatic logic [GS_W-1:0] seek_group(input logic [STB_W-1:0] mask,
                                                   input logic [GS_W-1:0]  start);
        logic [7:0]      m8;
        logic [GS_W-1:0] res;
        logic            found;
        m8    = 8'(mask);
        res   = GS_W'(GROUPS);
        found = 1'b0;
        for (int g = 0; g < GROUPS; g++) begin
            if (!found && (GS_W'(g) >= start) && m8[g]) begin
                res   = GS_W'(g);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/tpls_line_buf.sv -----
`timescale 1ns / 1ps
// Line store of dot bytes with per-entry valid bits and a registered read port.
// Depends on tpls_pkg.
module tpls_line_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpls_pkg::t_buf_ctrl i_ctrl,
    output logic [7:0]          o_rd_byte
);

    logic [7:0]                  r_mem [tpls_pkg::LINE_MAX];
    logic [tpls_pkg::LINE_MAX-1:0] r_valid;
    logic [7:0]                  r_rd_byte;
    logic                        r_rd_ok;
    logic                        hit;

    assign hit = i_ctrl.we && (i_ctrl.waddr == i_ctrl.raddr);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= i_ctrl.wdata;
        end
        r_rd_byte <= hit ? i_ctrl.wdata : r_mem[i_ctrl.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end else if (i_ctrl.we) begin
                r_valid[i_ctrl.waddr] <= 1'b1;
            end
            if (i_ctrl.clear) begin
                r_rd_ok <= 1'b0;
            end else if (hit) begin
                r_rd_ok <= 1'b1;
            end else begin
                r_rd_ok <= r_valid[i_ctrl.raddr];
            end
        end
    end

    assign o_rd_byte = r_rd_ok ? r_rd_byte : 8'd0;

endmodule

// ----- sv/thermal_head_line_sequencer_core.sv -----
`timescale 1ns / 1ps
// Thermal print head line sequencer, top level.
// Depends on tpls_pkg and tpls_line_buf.
//
// Takes one transaction per clock unless the output stalls: write, start and tick
// items each make one result through the input register, one pass of logic and the
// result register. The line store is a 64-byte memory whose next byte is prefetched
// into a read register, so shifting also runs at one per clock unless stalled. Reset
// clears the store at once through per-byte valid bits; there is no clearing pass.
// The user must write the cfg port registers only while idle; it is not enforced.
module thermal_head_line_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // byte_index[5:0], byte_value[13:6], zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // shift_byte[7:0], shift_valid[8], latch_n[9],
                                       // strobe_res[15:10], busy_res[16], line_done[17],
                                       // rejected[18], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // configuration
    logic [6:0]                 r_line_bytes;
    logic [7:0]                 r_latch_ticks;
    logic [7:0]                 r_heat_ticks;
    logic [tpls_pkg::STB_W-1:0] r_strobe_mask;
    logic                       r_seq_heat;
    logic                       r_auto_clear;

    // input register
    logic        r_in_vld;
    logic [1:0]  r_in_cmd;
    logic [5:0]  r_in_idx;
    logic [7:0]  r_in_val;

    // sequencer state
    tpls_pkg::t_phase            r_phase, n_phase;
    logic [tpls_pkg::ADDR_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]                  r_tick_cnt, n_tick_cnt;
    logic [tpls_pkg::GI_W-1:0]   r_group, n_group;

    // result register
    logic        r_out_vld;
    logic [23:0] r_out_data;
    logic [23:0] res_data;

    logic                       adv, proc;
    logic [7:0]                 rd_byte;
    tpls_pkg::t_buf_ctrl        buf_ctrl;
    logic [tpls_pkg::STB_W-1:0] live_mask;
    logic [tpls_pkg::CNT_W-1:0] len, bc_inc;
    logic [tpls_pkg::GS_W-1:0]  seek;
    logic [7:0]                 tick_inc, latch_lim, heat_lim;
    logic [7:0]                 sbyte;
    logic                       svalid, latch, done, rej;
    logic [tpls_pkg::STB_W-1:0] strobe;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes  <= 7'd48;
            r_latch_ticks <= 8'd1;
            r_heat_ticks  <= 8'd10;
            r_strobe_mask <= tpls_pkg::STB_W'(63);
            r_seq_heat    <= 1'b1;
            r_auto_clear  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpls_pkg::REG_LINE_BYTES:  r_line_bytes  <= i_cfg_data[6:0];
                tpls_pkg::REG_LATCH_TICKS: r_latch_ticks <= i_cfg_data;
                tpls_pkg::REG_HEAT_TICKS:  r_heat_ticks  <= i_cfg_data;
                tpls_pkg::REG_STROBE_MASK: r_strobe_mask <= i_cfg_data[tpls_pkg::STB_W-1:0];
                tpls_pkg::REG_SEQ_HEAT:    r_seq_heat    <= i_cfg_data[0];
                tpls_pkg::REG_AUTO_CLEAR:  r_auto_clear  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign adv           = !r_out_vld || m_axis_tready;
    assign proc          = r_in_vld && adv;
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tuser;
            r_in_idx <= s_axis_tdata[5:0];
            r_in_val <= s_axis_tdata[13:6];
        end
    end

    assign live_mask = r_strobe_mask
                     & tpls_pkg::STB_W'((9'd1 << tpls_pkg::GROUPS) - 9'd1);

    always_comb begin
        if (r_line_bytes == 7'd0) begin
            len = tpls_pkg::CNT_W'(1);
        end else if (32'(r_line_bytes) > tpls_pkg::LINE_MAX) begin
            len = tpls_pkg::CNT_W'(tpls_pkg::LINE_MAX);
        end else begin
            len = tpls_pkg::CNT_W'(r_line_bytes);
        end
    end

    assign bc_inc    = tpls_pkg::CNT_W'(r_byte_cnt) + tpls_pkg::CNT_W'(1);
    assign tick_inc  = r_tick_cnt + 8'd1;
    assign latch_lim = (r_latch_ticks == 8'd0) ? 8'd1 : r_latch_ticks;
    assign heat_lim  = (r_heat_ticks == 8'd0) ? 8'd1 : r_heat_ticks;

    always_comb begin
        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_tick_cnt = r_tick_cnt;
        n_group    = r_group;
        sbyte      = 8'd0;
        svalid     = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        latch      = 1'b1;
        strobe     = '0;
        seek       = tpls_pkg::seek_group(live_mask,
                         (r_phase == tpls_pkg::PH_HEAT)
                         ? tpls_pkg::GS_W'(r_group) + tpls_pkg::GS_W'(1)
                         : '0);
        buf_ctrl.we    = 1'b0;
        buf_ctrl.waddr = tpls_pkg::ADDR_W'(r_in_idx);
        buf_ctrl.wdata = r_in_val;
        buf_ctrl.clear = 1'b0;

        unique case (r_phase)
            tpls_pkg::PH_LATCH: latch = 1'b0;
            tpls_pkg::PH_HEAT: begin
                if (r_seq_heat) begin
                    if (32'(r_group) < tpls_pkg::GROUPS) begin
                        strobe = tpls_pkg::STB_W'(8'd1 << r_group);
                    end
                end else begin
                    strobe = live_mask;
                end
            end
            default: ;
        endcase

        if (proc) begin
            case (r_in_cmd)
                tpls_pkg::CMD_WRITE: begin
                    if (r_phase != tpls_pkg::PH_IDLE) begin
                        rej = 1'b1;
                    end else if (32'(r_in_idx) < tpls_pkg::LINE_MAX) begin
                        buf_ctrl.we = 1'b1;
                    end
                end
                tpls_pkg::CMD_START: begin
                    if (r_phase != tpls_pkg::PH_IDLE) begin
                        rej = 1'b1;
                    end else begin
                        n_phase    = tpls_pkg::PH_SHIFT;
                        n_byte_cnt = '0;
                        n_tick_cnt = 8'd0;
                        n_group    = '0;
                    end
                end
                tpls_pkg::CMD_TICK: begin
                    unique case (r_phase)
                        tpls_pkg::PH_SHIFT: begin
                            sbyte  = rd_byte;
                            svalid = 1'b1;
                            if (bc_inc >= len) begin
                                n_byte_cnt = '0;
                                n_tick_cnt = 8'd0;
                                n_phase    = tpls_pkg::PH_LATCH;
                            end else begin
                                n_byte_cnt = tpls_pkg::ADDR_W'(bc_inc);
                            end
                        end
                        tpls_pkg::PH_LATCH: begin
                            n_tick_cnt = tick_inc;
                            if (tick_inc >= latch_lim) begin
                                n_tick_cnt     = 8'd0;
                                buf_ctrl.clear = r_auto_clear;
                                if (r_seq_heat) begin
                                    if (32'(seek) >= tpls_pkg::GROUPS) begin
                                        n_phase = tpls_pkg::PH_IDLE;
                                        done    = 1'b1;
                                    end else begin
                                        n_group = tpls_pkg::GI_W'(seek);
                                        n_phase = tpls_pkg::PH_HEAT;
                                    end
                                end else begin
                                    n_phase = tpls_pkg::PH_HEAT;
                                end
                            end
                        end
                        tpls_pkg::PH_HEAT: begin
                            n_tick_cnt = tick_inc;
                            if (tick_inc >= heat_lim) begin
                                n_tick_cnt = 8'd0;
                                if (r_seq_heat && (32'(seek) < tpls_pkg::GROUPS)) begin
                                    n_group = tpls_pkg::GI_W'(seek);
                                end else begin
                                    n_phase = tpls_pkg::PH_IDLE;
                                    done    = 1'b1;
                                    n_group = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        buf_ctrl.raddr = n_byte_cnt;
        res_data = {5'd0, rej, done, (n_phase != tpls_pkg::PH_IDLE), strobe, latch,
                    svalid, sbyte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tpls_pkg::PH_IDLE;
            r_byte_cnt <= '0;
            r_tick_cnt <= 8'd0;
            r_group    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_tick_cnt <= n_tick_cnt;
            r_group    <= n_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    tpls_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (buf_ctrl),
        .o_rd_byte (rd_byte)
    );

endmodule
